### rtl/tss_pkg.sv
// Shared constants for the triangle sphere subdivider.
package tss_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAX_DEPTH_DEF   = 3;

	// magnitude width after the pre-shift, and the fixed scale of the length
	localparam int MAG_W    = 16;
	localparam int SQ_SHIFT = 26;

	localparam logic [1:0] DEPTH_RESET = 2'd3;

endpackage

### rtl/tss_norm.sv
// Iterative vector normalizer: squares, bit-pair square root, restoring division.
module tss_norm #(
	parameter int COORD_WIDTH = tss_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0][COORD_WIDTH-1:0]  v,
	output logic                         done,
	output logic [2:0][COORD_WIDTH-1:0]  o
);

	localparam int W        = COORD_WIDTH;
	localparam int PRESHIFT = (W > tss_pkg::MAG_W) ? W - tss_pkg::MAG_W : 0;
	localparam int MAG_W    = tss_pkg::MAG_W;
	localparam int SUM_W    = 2 * MAG_W;
	localparam int RAD_W    = SUM_W + tss_pkg::SQ_SHIFT;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int KW       = $clog2(ROOT_W);
	localparam int DW       = W + 30;
	localparam int CW       = $clog2(W + 1) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_RINIT,
		S_ROOT,
		S_DLOAD,
		S_DIV,
		S_DSTORE
	} state_t;

	state_t               state_q;
	logic [MAG_W-1:0]     mag_q [0:2];
	logic [2:0]           neg_q;
	logic [1:0]           idx_q;
	logic [SUM_W-1:0]     s_q;
	logic [RAD_W-1:0]     rad_q;
	logic [RAD_W-1:0]     res_q;
	logic [KW-1:0]        k_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        den_q;
	logic [W:0]           quo_q;
	logic [CW-1:0]        cnt_q;
	logic [2:0][W-1:0]    o_q;
	logic                 done_q;

	logic [RAD_W-1:0]     bitv;
	logic [RAD_W-1:0]     trial;
	logic [DW-1:0]        num;
	logic [DW-1:0]        den;
	logic [2*MAG_W-1:0]   sq;

	function automatic logic [MAG_W-1:0] mag_of(input logic [W-1:0] x);
		logic [W-1:0] a;
		a = x[W-1] ? (~x + 1'b1) : x;
		return MAG_W'(a >> PRESHIFT);
	endfunction

	function automatic logic [W-1:0] sat_of(input logic [W:0] q, input logic neg);
		logic [W:0] half;
		half = (W+1)'(1) << (W - 1);
		if (neg) begin
			if (q > half)
				return {1'b1, {(W-1){1'b0}}};
			else
				return W'(~q + 1'b1);
		end else begin
			if (q >= half)
				return {1'b0, {(W-1){1'b1}}};
			else
				return q[W-1:0];
		end
	endfunction

	assign bitv  = RAD_W'(1) << {k_q, 1'b0};
	assign trial = res_q + bitv;
	assign sq    = mag_q[idx_q] * mag_q[idx_q];
	assign num   = (DW'(mag_q[idx_q]) << (W + 10)) + DW'(res_q >> 1);
	assign den   = DW'(res_q) << W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			idx_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_of(v[i]);
							neg_q[i] <= v[i][W-1];
						end
						s_q     <= '0;
						idx_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					s_q <= s_q + sq;
					if (idx_q == 2'd2)
						state_q <= S_RINIT;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_RINIT: begin
					if (s_q == '0) begin
						o_q     <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						rad_q   <= RAD_W'(s_q) << tss_pkg::SQ_SHIFT;
						res_q   <= '0;
						k_q     <= KW'(ROOT_W - 1);
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (rad_q >= trial) begin
						rad_q <= rad_q - trial;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
					if (k_q == '0) begin
						idx_q   <= '0;
						state_q <= S_DLOAD;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_DLOAD: begin
					// quotient at or above 2^(W+1) saturates anyway
					if (num >= (den << 1)) begin
						quo_q   <= '1;
						state_q <= S_DSTORE;
					end else begin
						rem_q   <= num;
						den_q   <= den;
						quo_q   <= '0;
						cnt_q   <= CW'(W);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_q >= den_q) begin
						rem_q <= rem_q - den_q;
						quo_q <= {quo_q[W-1:0], 1'b1};
					end else begin
						quo_q <= {quo_q[W-1:0], 1'b0};
					end
					den_q <= den_q >> 1;
					if (cnt_q == '0)
						state_q <= S_DSTORE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_DSTORE: begin
					o_q[idx_q] <= sat_of(quo_q, neg_q[idx_q]);
					if (idx_q == 2'd2) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DLOAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign o    = o_q;

endmodule

### rtl/triangle_sphere_subdivider_unit.sv
// Top level of the triangle sphere subdivider: split sequencer and level store.
//
// Input channel (in_valid/in_stall): one triangle a, b, c of signed
// fixed-point corners. in_stall is high from the request accepted until
// its last output triangle has been taken.
// Output channel (out_valid/out_stall): 4^depth triangles per input,
// depth first, children in order a, b, c, middle; last_of_run marks the
// final one. A stalled output holds its values and the block waits.
// Config channel (cfg_valid/cfg_ready, always ready): subdivision depth,
// clamped to MAX_DEPTH; write only while idle. Reset sets depth 3.
// Cost: every edge midpoint takes three normalizations on the single
// shared normalizer, which finishes early for zero-length or saturating
// vectors, so a child triangle costs nine normalizations.
// Only levels whose path digit changed are rebuilt: at depth d this is
// the sum over l from 1 to d of 4^l children per input (84 at depth 3).
// Depth zero passes the triangle through unchanged.
// Reset returns the sequencer to idle; the level store is not cleared.
module triangle_sphere_subdivider_unit #(
	parameter int MAX_DEPTH   = tss_pkg::MAX_DEPTH_DEF,
	parameter int COORD_WIDTH = tss_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] c_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_a_x,
	output logic signed [COORD_WIDTH-1:0] out_a_y,
	output logic signed [COORD_WIDTH-1:0] out_a_z,
	output logic signed [COORD_WIDTH-1:0] out_b_x,
	output logic signed [COORD_WIDTH-1:0] out_b_y,
	output logic signed [COORD_WIDTH-1:0] out_b_z,
	output logic signed [COORD_WIDTH-1:0] out_c_x,
	output logic signed [COORD_WIDTH-1:0] out_c_y,
	output logic signed [COORD_WIDTH-1:0] out_c_z,
	output logic                          last_of_run
);

	localparam int W  = COORD_WIDTH;
	localparam int LW = (MAX_DEPTH > 1) ? 2 : 1;

	typedef enum logic [2:0] {
		T_IDLE,
		T_MSTART,
		T_MWAIT,
		T_CHILD,
		T_OUT
	} state_t;

	state_t            state_q;
	logic [1:0]        depth_q;
	logic [1:0]        dep_q;
	logic [5:0]        n_q;
	logic [LW-1:0]     lvl_q;
	logic [1:0]        edg_q;
	logic [1:0]        ph_q;
	logic              last_q;

	logic [W-1:0]      tri_q [0:MAX_DEPTH][0:8];
	logic [W-1:0]      np_q  [0:2];
	logic [W-1:0]      sum_q [0:2];
	logic [W-1:0]      mid_q [0:2][0:2];
	logic [W-1:0]      out_q [0:8];

	logic [W-1:0]      cor   [0:2][0:2];
	logic [W-1:0]      child [0:8];
	logic [LW-1:0]     plvl;
	logic [1:0]        pe;
	logic [1:0]        qe;
	logic [1:0]        dig;
	logic [1:0]        dep_in;
	logic [5:0]        nn;
	logic [LW-1:0]     sl;
	logic              accept;
	logic              nrm_start;
	logic              nrm_done;
	logic [2:0][W-1:0] nrm_v;
	logic [2:0][W-1:0] nrm_o;

	function automatic logic [1:0] digit_of(input logic [5:0] n, input logic [1:0] d,
		input logic [1:0] l);
		logic [5:0] sh;
		sh = n >> {d - l, 1'b0};
		return sh[1:0];
	endfunction

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1])
			return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			return s[W-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && (state_q == T_IDLE);
	assign out_valid = (state_q == T_OUT);
	assign nrm_start = (state_q == T_MSTART);
	assign dep_in    = (32'(depth_q) > MAX_DEPTH) ? 2'(MAX_DEPTH) : depth_q;
	assign plvl      = lvl_q - 1'b1;
	assign pe        = edg_q;
	assign qe        = (edg_q == 2'd2) ? 2'd0 : edg_q + 1'b1;
	assign dig       = digit_of(n_q, dep_q, 2'(lvl_q));
	assign nn        = n_q + 1'b1;

	always_comb begin
		for (int c = 0; c < 3; c++)
			for (int i = 0; i < 3; i++)
				cor[c][i] = tri_q[plvl][3*c+i];
		for (int i = 0; i < 3; i++) begin
			if (ph_q == 2'd0)
				nrm_v[i] = cor[pe][i];
			else if (ph_q == 2'd1)
				nrm_v[i] = cor[qe][i];
			else
				nrm_v[i] = sum_q[i];
		end
	end

	// mids: 0 = ab, 1 = bc, 2 = ca
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unique case (dig)
				2'd0: begin
					child[i] = cor[0][i]; child[3+i] = mid_q[0][i]; child[6+i] = mid_q[2][i];
				end
				2'd1: begin
					child[i] = cor[1][i]; child[3+i] = mid_q[1][i]; child[6+i] = mid_q[0][i];
				end
				2'd2: begin
					child[i] = cor[2][i]; child[3+i] = mid_q[2][i]; child[6+i] = mid_q[1][i];
				end
				default: begin
					child[i] = mid_q[0][i]; child[3+i] = mid_q[1][i]; child[6+i] = mid_q[2][i];
				end
			endcase
		end
	end

	// first level whose path digit moves on the next triangle
	always_comb begin
		sl = LW'(dep_q);
		for (int l = MAX_DEPTH; l >= 1; l--) begin
			if (2'(l) <= dep_q && digit_of(nn, dep_q, 2'(l)) != digit_of(n_q, dep_q, 2'(l)))
				sl = LW'(l);
		end
	end

	tss_norm #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (nrm_start),
		.v     (nrm_v),
		.done  (nrm_done),
		.o     (nrm_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			depth_q <= tss_pkg::DEPTH_RESET;
			dep_q   <= '0;
			n_q     <= '0;
			lvl_q   <= '0;
			edg_q   <= '0;
			ph_q    <= '0;
			last_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				depth_q <= cfg_data;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						dep_q <= dep_in;
						n_q   <= '0;
						lvl_q <= LW'(1);
						edg_q <= '0;
						ph_q  <= '0;
						if (dep_in == 2'd0) begin
							last_q  <= 1'b1;
							state_q <= T_OUT;
						end else begin
							state_q <= T_MSTART;
						end
					end
				end
				T_MSTART: state_q <= T_MWAIT;
				T_MWAIT: begin
					if (nrm_done) begin
						if (ph_q == 2'd2) begin
							ph_q <= '0;
							if (edg_q == 2'd2) begin
								state_q <= T_CHILD;
							end else begin
								edg_q   <= edg_q + 1'b1;
								state_q <= T_MSTART;
							end
						end else begin
							ph_q    <= ph_q + 1'b1;
							state_q <= T_MSTART;
						end
					end
				end
				T_CHILD: begin
					edg_q <= '0;
					if (2'(lvl_q) == dep_q) begin
						last_q  <= (n_q == 6'((7'd1 << {dep_q, 1'b0}) - 7'd1));
						state_q <= T_OUT;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= T_MSTART;
					end
				end
				T_OUT: begin
					if (!out_stall) begin
						if (last_q) begin
							state_q <= T_IDLE;
						end else begin
							n_q     <= nn;
							lvl_q   <= sl;
							edg_q   <= '0;
							ph_q    <= '0;
							state_q <= T_MSTART;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q[0][0] <= a_x; tri_q[0][1] <= a_y; tri_q[0][2] <= a_z;
			tri_q[0][3] <= b_x; tri_q[0][4] <= b_y; tri_q[0][5] <= b_z;
			tri_q[0][6] <= c_x; tri_q[0][7] <= c_y; tri_q[0][8] <= c_z;
			out_q[0] <= a_x; out_q[1] <= a_y; out_q[2] <= a_z;
			out_q[3] <= b_x; out_q[4] <= b_y; out_q[5] <= b_z;
			out_q[6] <= c_x; out_q[7] <= c_y; out_q[8] <= c_z;
		end
		if (state_q == T_MWAIT && nrm_done) begin
			for (int i = 0; i < 3; i++) begin
				if (ph_q == 2'd0)
					np_q[i] <= nrm_o[i];
				else if (ph_q == 2'd1)
					sum_q[i] <= sat_add(np_q[i], nrm_o[i]);
				else
					mid_q[edg_q][i] <= nrm_o[i];
			end
		end
		if (state_q == T_CHILD) begin
			for (int i = 0; i < 9; i++) begin
				tri_q[lvl_q][i] <= child[i];
				out_q[i]        <= child[i];
			end
		end
	end

	assign out_a_x     = out_q[0];
	assign out_a_y     = out_q[1];
	assign out_a_z     = out_q[2];
	assign out_b_x     = out_q[3];
	assign out_b_y     = out_q[4];
	assign out_b_z     = out_q[5];
	assign out_c_x     = out_q[6];
	assign out_c_y     = out_q[7];
	assign out_c_z     = out_q[8];
	assign last_of_run = last_q;

endmodule
